// ===== sv/linear_recurrence_matrix_power_mod_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef LINEAR_RECURRENCE_MATRIX_POWER_MOD_TOP_ASSERT_SVH
`define LINEAR_RECURRENCE_MATRIX_POWER_MOD_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrmp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrmp assertion failed");

`endif

// ===== sv/lrmp_pkg.sv =====
package lrmp_pkg;
    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 5;
    localparam int VALUE_W  = 32;
    localparam int TERM_W   = 31;
    localparam int NIDX_W   = 31;
    localparam int ORDER_W  = 5;
    localparam int MOD_W    = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;

    typedef logic [MODE_W-1:0]         t_mode;
    typedef logic [SLOT_W-1:0]         t_slot;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [NIDX_W-1:0]         t_nidx;
    typedef logic [TERM_W-1:0]         t_term;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;

    localparam t_mode MODE_COEF  = 2'd0;
    localparam t_mode MODE_INIT  = 2'd1;
    localparam t_mode MODE_QUERY = 2'd2;

    localparam t_cfg_idx CFG_ORDER   = 1'b0;
    localparam t_cfg_idx CFG_MODULUS = 1'b1;
endpackage

// ===== sv/lrmp_if.sv =====
interface lrmp_in_if;
    import lrmp_pkg::*;
    logic   valid;
    logic   ready;
    t_mode  mode;
    t_slot  slot;
    t_value value;
    t_nidx  term_index;
    modport source (output valid, mode, slot, value, term_index, input ready);
    modport sink (input valid, mode, slot, value, term_index, output ready);
endinterface

interface lrmp_out_if;
    import lrmp_pkg::*;
    logic  valid;
    logic  ready;
    t_term term_value;
    modport source (output valid, term_value, input ready);
    modport sink (input valid, term_value, output ready);
endinterface

// ===== sv/lrmp_ram.sv =====
module lrmp_ram #(
    parameter int W = 31,
    parameter int D = 1024,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/linear_recurrence_matrix_power_mod_top.sv =====
// Channel   Dir  Payload                                  Meaning
// i_in      in   mode, slot, value, term_index            load coefficient/initial term, query
// o_out     out  term_value                               f(n) mod m, one item per query
// i_cfg_*   in   index 0 order, index 1 modulus           plain write port, no read-back
//
// Query with n >= k: build the base and identity matrices, then square and multiply
// with at most 2*floor(log2(n-k+1))+1 matrix products, then the dot product; every
// multiply runs through the bit-serial mulmod.
// Reset: synchronous, active low; clears order/modulus to 1 and all stored terms.
// Stalls: i_in is ready only while idle; a finished result waits in the output
// register, and the next query holds before writing it until it is taken.
module linear_recurrence_matrix_power_mod_top #(
    parameter int MAX_ORDER = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lrmp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lrmp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lrmp_in_if.sink                     i_in,
    lrmp_out_if.source                  o_out
);
    import lrmp_pkg::*;

    localparam int DIM = MAX_ORDER + 1;
    localparam int IW  = $clog2(MAX_ORDER + 1);
    localparam int AW  = $clog2(DIM * DIM);
    localparam int KCW = (IW > SLOT_W) ? IW : SLOT_W;

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_UNIT   = 5'd1;
    localparam logic [4:0] S_LDWR   = 5'd2;
    localparam logic [4:0] S_SMALL  = 5'd3;
    localparam logic [4:0] S_INIT   = 5'd4;
    localparam logic [4:0] S_INITWR = 5'd5;
    localparam logic [4:0] S_EXP    = 5'd6;
    localparam logic [4:0] S_EXP2   = 5'd7;
    localparam logic [4:0] S_MMRX   = 5'd8;
    localparam logic [4:0] S_MMRY   = 5'd9;
    localparam logic [4:0] S_MMGO   = 5'd10;
    localparam logic [4:0] S_MMACC  = 5'd11;
    localparam logic [4:0] S_CPRD   = 5'd12;
    localparam logic [4:0] S_CPWR   = 5'd13;
    localparam logic [4:0] S_DTRD   = 5'd14;
    localparam logic [4:0] S_DTGO   = 5'd15;
    localparam logic [4:0] S_DTACC  = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] row,
                                             input logic [IW-1:0] col);
        f_addr = AW'(row) * AW'(DIM) + AW'(col);
    endfunction

    logic [4:0]         r_state, r_ret;
    logic [ORDER_W-1:0] r_order;
    logic [MOD_W-1:0]   r_modulus;
    logic [TERM_W-1:0]  r_coef [DIM];
    logic [TERM_W-1:0]  r_init [MAX_ORDER];
    logic [IW-1:0]      r_i, r_j, r_t;
    logic [31:0]        r_p;
    logic               r_sq;       // current product squares base
    logic [TERM_W-1:0]  r_acc;
    logic [TERM_W-1:0]  r_ua, r_uacc;
    logic [31:0]        r_ub;
    logic [4:0]         r_ucnt;
    t_mode              r_mode;
    t_slot              r_slot;
    logic               r_neg;
    t_term              r_term;
    logic               r_out_valid;

    logic [MOD_W-1:0]  m_eff, one;
    logic [31:0]       m32;
    logic [IW-1:0]     k;
    logic [31:0]       u_d, u_d1, u_s, u_s1;
    logic [31:0]       a_s, a_s1;
    logic [TERM_W-1:0] n_uacc, n_acc;
    logic [31:0]       n_p;
    logic [31:0]       abs_val;
    logic              need_red, sweep_end;
    logic [TERM_W-1:0] base_val, ld_val;

    logic              pw_we, bs_we, sc_we;
    logic [AW-1:0]     pw_raddr, bs_raddr, sc_raddr, ij_addr;
    logic [TERM_W-1:0] pw_wdata, bs_wdata, pw_rd, bs_rd, sc_rd;

    assign m_eff = (r_modulus == '0) ? MOD_W'(1) : r_modulus;
    assign m32   = {1'b0, m_eff};
    assign one   = (m_eff == MOD_W'(1)) ? '0 : MOD_W'(1);
    assign k     = ({1'b0, r_order} > 6'(MAX_ORDER)) ? IW'(MAX_ORDER) : IW'(r_order);

    // bit-serial mulmod step: acc = 2*acc + bit*ua, both reduced
    always_comb begin
        u_d    = {r_uacc, 1'b0};
        u_d1   = (u_d >= m32) ? u_d - m32 : u_d;
        u_s    = u_d1 + (r_ub[31] ? {1'b0, r_ua} : 32'd0);
        u_s1   = (u_s >= m32) ? u_s - m32 : u_s;
        n_uacc = u_s1[TERM_W-1:0];
        a_s    = {1'b0, r_acc} + {1'b0, r_uacc};
        a_s1   = (a_s >= m32) ? a_s - m32 : a_s;
        n_acc  = a_s1[TERM_W-1:0];
        n_p    = r_p >> 1;
    end

    assign abs_val   = i_in.value[31] ? (~i_in.value + 32'd1) : i_in.value;
    assign ld_val    = (r_neg && r_uacc != '0) ? (m_eff - r_uacc) : r_uacc;
    assign need_red  = (r_i == '0) && (r_j < k);
    assign sweep_end = (r_i == k) && (r_j == k);
    assign ij_addr   = f_addr(r_i, r_j);

    // companion matrix entry for the initial sweep
    always_comb begin
        priority if (r_i == '0 && r_j == k) begin
            base_val = one;
        end else if (r_i != '0 && r_i < k && r_j == r_i - IW'(1)) begin
            base_val = one;
        end else if (r_i == k && r_j == k) begin
            base_val = one;
        end else begin
            base_val = '0;
        end
    end

    // memory port control
    always_comb begin
        pw_we    = (r_state == S_INIT) || (r_state == S_CPWR && !r_sq);
        pw_wdata = (r_state == S_INIT) ? ((r_i == r_j) ? one : '0) : sc_rd;
        bs_we    = (r_state == S_INIT && !need_red) || (r_state == S_INITWR) ||
                   (r_state == S_CPWR && r_sq);
        unique case (r_state)
            S_INIT:   bs_wdata = base_val;
            S_INITWR: bs_wdata = r_uacc;
            default:  bs_wdata = sc_rd;
        endcase
        sc_we    = (r_state == S_MMACC) && (r_t == k);
        bs_raddr = (r_state == S_MMRX) ? f_addr(r_i, r_t) : f_addr(r_t, r_j);
        pw_raddr = (r_state == S_DTRD) ? AW'(r_i) : f_addr(r_i, r_t);
        sc_raddr = ij_addr;
    end

    lrmp_ram #(.W(TERM_W), .D(DIM * DIM)) u_base (
        .i_clk(i_clk), .i_we(bs_we), .i_waddr(ij_addr), .i_wdata(bs_wdata),
        .i_raddr(bs_raddr), .o_rdata(bs_rd)
    );
    lrmp_ram #(.W(TERM_W), .D(DIM * DIM)) u_power (
        .i_clk(i_clk), .i_we(pw_we), .i_waddr(ij_addr), .i_wdata(pw_wdata),
        .i_raddr(pw_raddr), .o_rdata(pw_rd)
    );
    lrmp_ram #(.W(TERM_W), .D(DIM * DIM)) u_scratch (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(ij_addr), .i_wdata(n_acc),
        .i_raddr(sc_raddr), .o_rdata(sc_rd)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.term_value = r_term;

    // control and stored terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_order     <= ORDER_W'(1);
            r_modulus   <= MOD_W'(1);
            for (int e = 0; e < DIM; e++) begin
                r_coef[e] <= '0;
            end
            for (int e = 0; e < MAX_ORDER; e++) begin
                r_init[e] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ORDER:   r_order   <= i_cfg_data[ORDER_W-1:0];
                    CFG_MODULUS: r_modulus <= i_cfg_data;
                    default:     ;
                endcase
            end

            if (r_state == S_OUT && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        unique case (i_in.mode)
                            MODE_COEF: begin
                                if (KCW'(i_in.slot) <= KCW'(k)) r_state <= S_UNIT;
                            end
                            MODE_INIT: begin
                                if (KCW'(i_in.slot) < KCW'(k)) r_state <= S_UNIT;
                            end
                            MODE_QUERY: begin
                                r_state <= (i_in.term_index < NIDX_W'(k)) ? S_UNIT : S_INIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_UNIT: begin
                    if (r_ucnt == 5'd31) r_state <= r_ret;
                end
                S_LDWR: begin
                    if (r_mode == MODE_COEF) begin
                        r_coef[IW'(r_slot)] <= ld_val;
                    end else begin
                        r_init[IW'(r_slot)] <= ld_val;
                    end
                    r_state <= S_IDLE;
                end
                S_SMALL:  r_state <= S_OUT;
                S_INIT: begin
                    if (need_red) r_state <= S_UNIT;
                    else if (sweep_end) r_state <= S_EXP;
                end
                S_INITWR: r_state <= sweep_end ? S_EXP : S_INIT;
                S_EXP: begin
                    priority if (r_p == '0) r_state <= S_DTRD;
                    else if (r_p[0]) r_state <= S_MMRX;
                    else r_state <= S_EXP2;
                end
                S_EXP2:   r_state <= (n_p != '0) ? S_MMRX : S_DTRD;
                S_MMRX:   r_state <= S_MMRY;
                S_MMRY:   r_state <= S_MMGO;
                S_MMGO:   r_state <= S_UNIT;
                S_MMACC: begin
                    r_state <= (r_t == k && sweep_end) ? S_CPRD : S_MMRX;
                end
                S_CPRD:   r_state <= S_CPWR;
                S_CPWR: begin
                    if (sweep_end) r_state <= r_sq ? S_EXP : S_EXP2;
                    else r_state <= S_CPRD;
                end
                S_DTRD:   r_state <= S_DTGO;
                S_DTGO:   r_state <= S_UNIT;
                S_DTACC:  r_state <= (r_i == k) ? S_OUT : S_DTRD;
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) r_state <= S_IDLE;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_mode <= i_in.mode;
                r_slot <= i_in.slot;
                r_neg  <= i_in.value[31];
                r_ua   <= one;
                r_uacc <= '0;
                r_ucnt <= '0;
                r_i    <= '0;
                r_j    <= '0;
                r_p    <= {1'b0, i_in.term_index} - 32'(k) + 32'd1;
                if (i_in.mode == MODE_QUERY) begin
                    r_ub  <= {1'b0, r_init[IW'(i_in.term_index)]};
                    r_ret <= S_SMALL;
                end else begin
                    r_ub  <= abs_val;
                    r_ret <= S_LDWR;
                end
            end
            S_UNIT: begin
                r_uacc <= n_uacc;
                r_ub   <= r_ub << 1;
                r_ucnt <= r_ucnt + 5'd1;
            end
            S_SMALL: r_acc <= r_uacc;
            S_INIT, S_INITWR: begin
                if (r_state == S_INIT && need_red) begin
                    r_ua   <= one;
                    r_ub   <= {1'b0, r_coef[r_j]};
                    r_uacc <= '0;
                    r_ucnt <= '0;
                    r_ret  <= S_INITWR;
                end else if (r_j == k) begin
                    r_j <= '0;
                    r_i <= r_i + IW'(1);
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
            S_EXP: begin
                r_sq  <= 1'b0;
                r_i   <= '0;
                r_j   <= '0;
                r_t   <= '0;
                r_acc <= '0;
            end
            S_EXP2: begin
                r_p   <= n_p;
                r_sq  <= 1'b1;
                r_i   <= '0;
                r_j   <= '0;
                r_t   <= '0;
                r_acc <= '0;
            end
            S_MMRY: r_ua <= r_sq ? bs_rd : pw_rd;
            S_MMGO: begin
                r_ub   <= {1'b0, bs_rd};
                r_uacc <= '0;
                r_ucnt <= '0;
                r_ret  <= S_MMACC;
            end
            S_MMACC: begin
                if (r_t == k) begin
                    r_acc <= '0;
                    r_t   <= '0;
                    if (r_j == k) begin
                        r_j <= '0;
                        r_i <= (r_i == k) ? '0 : r_i + IW'(1);
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end else begin
                    r_acc <= n_acc;
                    r_t   <= r_t + IW'(1);
                end
            end
            S_CPWR: begin
                if (r_j == k) begin
                    r_j <= '0;
                    r_i <= sweep_end ? '0 : r_i + IW'(1);
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
            S_DTGO: begin
                r_ua   <= pw_rd;
                r_ub   <= {1'b0, (r_i == k) ? r_coef[k] : r_init[k - IW'(1) - r_i]};
                r_uacc <= '0;
                r_ucnt <= '0;
                r_ret  <= S_DTACC;
            end
            S_DTACC: begin
                r_acc <= n_acc;
                r_i   <= r_i + IW'(1);
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) r_term <= r_acc;
            end
            default: ;
        endcase
    end
endmodule

// ===== sv/lrmp_checker.sv =====
module lrmp_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [lrmp_pkg::TERM_W-1:0] i_term_value
);
    `include "linear_recurrence_matrix_power_mod_top_assert.svh"

    // stalled result holds
    `LRMP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `LRMP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_term_value))
    // no item finishes in the cycle right after it is taken
    `LRMP_ASSERT_NEXT(a_no_instant, i_clk, i_rst_n, i_in_valid && i_in_ready, !$rose(i_out_valid))
    // ready only drops because an item was taken
    `LRMP_ASSERT_IMP(a_ready_drop, i_clk, i_rst_n, $fell(i_in_ready), $past(i_in_valid))
endmodule

bind linear_recurrence_matrix_power_mod_top lrmp_checker u_lrmp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_term_value (o_out.term_value)
);
